// ===== src/obd_adapter_reply_line_parser_top_macros.svh =====
// Assertion macros used by the reply line parser top module.
`ifndef OBD_ADAPTER_REPLY_LINE_PARSER_TOP_MACROS_SVH
`define OBD_ADAPTER_REPLY_LINE_PARSER_TOP_MACROS_SVH

// Checks a property on every rising clock edge while out of reset.
`define OARLP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define OARLP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/oarlp_pkg.sv =====
// Package with types, character codes and keyword tables for the reply line parser.
`timescale 1ns / 1ps
package oarlp_pkg;

  localparam int unsigned MaxDataBytesDefault = 8;

  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_GT    = 8'h3E;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_T     = 8'h54;

  localparam int unsigned KwCount = 5;
  localparam int unsigned KwMaxLen = 9;
  localparam int unsigned AtBit = 5;

  typedef enum logic [3:0] {
    KIND_PROMPT    = 4'd0,
    KIND_OK        = 4'd1,
    KIND_STOPPED   = 4'd2,
    KIND_QUERY     = 4'd3,
    KIND_NO_DATA   = 4'd4,
    KIND_CAN_ERROR = 4'd5,
    KIND_AT        = 4'd6,
    KIND_FRAME     = 4'd7,
    KIND_BAD       = 4'd8
  } line_kind_e;

  localparam logic [4:0] KW_LEN [KwCount] = '{5'd2, 5'd7, 5'd1, 5'd7, 5'd9};

  localparam logic [7:0] KW_TEXT [KwCount][KwMaxLen] = '{
    '{"O", "K", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"S", "T", "O", "P", "P", "E", "D", 8'h00, 8'h00},
    '{"?", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"N", "O", " ", "D", "A", "T", "A", 8'h00, 8'h00},
    '{"C", "A", "N", " ", "E", "R", "R", "O", "R"}
  };

  typedef struct packed {
    logic        produce;
    line_kind_e  kind;
    logic [11:0] frame_id;
    logic [3:0]  frame_length;
    logic [63:0] frame_bytes;
  } line_result_t;

  // Value of a hex digit, or 16 for any other character.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'd16;
    if (c >= "0" && c <= "9") begin
      v = 5'(c - "0");
    end else if (c >= "A" && c <= "F") begin
      v = 5'(c - "A" + 8'd10);
    end else if (c >= "a" && c <= "f") begin
      v = 5'(c - "a" + 8'd10);
    end
    return v;
  endfunction

endpackage

// ===== src/obd_adapter_reply_line_parser_top.sv =====
// Channel   | Direction | Word contents
// s_axis    | in        | tdata[7:0] rx_char
// m_axis    | out       | tdata[3:0] line_kind, [15:4] frame_id, [19:16] frame_length,
//           |           | [83:20] frame_bytes, [87:84] zero
// One character is accepted per cycle while the input is not stalled; the result of a closing
// character passes through the input register, then the result register, before it is valid.
// Reset clears the line state and both valid flags; no clearing pass is needed.
// Input stalls only when a closing character meets a full, unread result register.
`timescale 1ns / 1ps
`include "obd_adapter_reply_line_parser_top_macros.svh"
module obd_adapter_reply_line_parser_top import oarlp_pkg::*; #(
  parameter int unsigned MAX_DATA_BYTES = MaxDataBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] rx_char
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata   // line_kind, frame_id, frame_length, frame_bytes
);

  logic         in_valid_q, in_valid_d;
  logic [7:0]   char_q;
  logic         out_valid_q, out_valid_d;
  line_result_t out_q;
  line_result_t res;
  logic         step;
  logic         out_free;

  oarlp_parser #(
    .MAX_DATA_BYTES(MAX_DATA_BYTES)
  ) u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .char_i  (char_q),
    .result_o(res)
  );

  assign out_free      = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && (!res.produce || out_free);
  assign s_axis_tready = !in_valid_q || step;
  assign in_valid_d    = s_axis_tvalid || (in_valid_q && !step);
  assign out_valid_d   = (out_valid_q && !m_axis_tready) || (step && res.produce);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= in_valid_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      char_q <= s_axis_tdata;
    end
    if (step && res.produce) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_q.frame_bytes, out_q.frame_length,
                          out_q.frame_id, out_q.kind};

  `OARLP_ASSERT(a_stall_only_when_full, !s_axis_tready |-> (in_valid_q && out_valid_q), "input stalled while result register free")
  `OARLP_ASSERT(a_plain_char_no_result, (step && char_q != CHAR_CR && char_q != CHAR_GT) |-> !res.produce, "result from a character that does not close a line")
  `OARLP_ASSERT(a_non_frame_zero, (m_axis_tvalid && out_q.kind != KIND_FRAME) |-> (out_q.frame_id == 12'd0 && out_q.frame_length == 4'd0 && out_q.frame_bytes == 64'd0), "frame fields set on a non-frame line")
  `OARLP_ASSERT(a_frame_length_max, (m_axis_tvalid && out_q.kind == KIND_FRAME) |-> (32'(out_q.frame_length) <= MAX_DATA_BYTES), "frame longer than the data byte limit")
  `OARLP_ASSERT_NEXT(a_result_loaded, (step && res.produce), m_axis_tvalid, "closed line did not reach the result register")

endmodule

// ===== src/oarlp_parser.sv =====
// Running line state and combinational line classification for the reply line parser.
`timescale 1ns / 1ps
module oarlp_parser import oarlp_pkg::*; #(
  parameter int unsigned MAX_DATA_BYTES = MaxDataBytesDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         step_i,
  input  logic [7:0]   char_i,
  output line_result_t result_o
);

  localparam logic [5:0] DATA_DIGITS_MAX = 6'(2 * MAX_DATA_BYTES);

  logic [4:0]  line_count_q, line_count_d;
  logic [4:0]  digit_count_q, digit_count_d;
  logic [11:0] id_accum_q, id_accum_d;
  logic [3:0]  length_digit_q, length_digit_d;
  logic [63:0] byte_store_q, byte_store_d;
  logic        bad_char_q, bad_char_d;
  logic [5:0]  alive_q, alive_d;

  logic [4:0]  abs_line_count;
  logic [4:0]  abs_digit_count;
  logic [11:0] abs_id;
  logic [3:0]  abs_length;
  logic [63:0] abs_bytes;
  logic        abs_bad;
  logic [5:0]  abs_alive;
  logic [4:0]  hex;
  logic [4:0]  data_idx;
  logic [3:0]  nib_idx;

  logic [4:0]  cls_line_count;
  logic [4:0]  cls_digit_count;
  logic [3:0]  cls_length;
  logic        cls_bad;
  logic [5:0]  cls_alive;
  logic [4:0]  cls_data_digits;
  logic        is_cr;
  logic        is_gt;
  logic        is_lf;

  assign is_cr = (char_i == CHAR_CR);
  assign is_gt = (char_i == CHAR_GT);
  assign is_lf = (char_i == CHAR_LF);

  // State after taking the character into the current line.
  always_comb begin
    abs_alive       = alive_q;
    abs_digit_count = digit_count_q;
    abs_id          = id_accum_q;
    abs_length      = length_digit_q;
    abs_bytes       = byte_store_q;
    abs_bad         = bad_char_q;
    hex             = hex_value(char_i);
    data_idx        = digit_count_q - 5'd4;
    nib_idx         = {data_idx[3:1], ~data_idx[0]};

    for (int k = 0; k < KwCount; k++) begin
      if (!(line_count_q < KW_LEN[k] && KW_TEXT[k][line_count_q[3:0]] == char_i)) begin
        abs_alive[k] = 1'b0;
      end
    end
    if ((line_count_q == 5'd0 && char_i != CHAR_A) ||
        (line_count_q == 5'd1 && char_i != CHAR_T)) begin
      abs_alive[AtBit] = 1'b0;
    end

    if (char_i != CHAR_SPACE) begin
      if (hex[4]) begin
        abs_bad = 1'b1;
      end else if (digit_count_q < 5'd3) begin
        abs_id = {id_accum_q[7:0], hex[3:0]};
      end else if (digit_count_q == 5'd3) begin
        abs_length = hex[3:0];
      end else if ({1'b0, data_idx} >= DATA_DIGITS_MAX) begin
        abs_bad = 1'b1;
      end else begin
        for (int n = 0; n < 16; n++) begin
          if (nib_idx == 4'(n)) begin
            abs_bytes[4*n +: 4] = byte_store_q[4*n +: 4] | hex[3:0];
          end
        end
      end
      abs_digit_count = (digit_count_q < 5'd31) ? digit_count_q + 5'd1 : 5'd31;
    end
    abs_line_count = (line_count_q < 5'd31) ? line_count_q + 5'd1 : 5'd31;
  end

  // A carriage return classifies the line as it stands; a '>' is part of the line.
  assign cls_line_count  = is_gt ? abs_line_count  : line_count_q;
  assign cls_digit_count = is_gt ? abs_digit_count : digit_count_q;
  assign cls_length      = is_gt ? abs_length      : length_digit_q;
  assign cls_bad         = is_gt ? abs_bad         : bad_char_q;
  assign cls_alive       = is_gt ? abs_alive       : alive_q;
  assign cls_data_digits = cls_digit_count - 5'd4;

  always_comb begin
    result_o              = '0;
    result_o.kind         = KIND_BAD;
    result_o.produce      = is_gt || (is_cr && line_count_q != 5'd0);
    if (cls_alive[AtBit] && cls_line_count >= 5'd2) begin
      result_o.kind = KIND_AT;
    end else if (is_gt && line_count_q == 5'd0) begin
      result_o.kind = KIND_PROMPT;
    end else begin
      for (int k = KwCount - 1; k >= 0; k--) begin
        if (cls_alive[k] && cls_line_count == KW_LEN[k]) begin
          result_o.kind = line_kind_e'(4'(k + 1));
        end
      end
      if (result_o.kind == KIND_BAD && !cls_bad && cls_digit_count >= 5'd4 &&
          !cls_data_digits[0] && cls_data_digits[4:1] == cls_length) begin
        result_o.kind         = KIND_FRAME;
        result_o.frame_id     = is_gt ? abs_id : id_accum_q;
        result_o.frame_length = cls_length;
        result_o.frame_bytes  = is_gt ? abs_bytes : byte_store_q;
      end
    end
  end

  always_comb begin
    line_count_d   = line_count_q;
    digit_count_d  = digit_count_q;
    id_accum_d     = id_accum_q;
    length_digit_d = length_digit_q;
    byte_store_d   = byte_store_q;
    bad_char_d     = bad_char_q;
    alive_d        = alive_q;
    if (is_cr || is_gt) begin
      line_count_d   = '0;
      digit_count_d  = '0;
      id_accum_d     = '0;
      length_digit_d = '0;
      byte_store_d   = '0;
      bad_char_d     = 1'b0;
      alive_d        = '1;
    end else if (!is_lf) begin
      line_count_d   = abs_line_count;
      digit_count_d  = abs_digit_count;
      id_accum_d     = abs_id;
      length_digit_d = abs_length;
      byte_store_d   = abs_bytes;
      bad_char_d     = abs_bad;
      alive_d        = abs_alive;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_count_q   <= '0;
      digit_count_q  <= '0;
      id_accum_q     <= '0;
      length_digit_q <= '0;
      byte_store_q   <= '0;
      bad_char_q     <= 1'b0;
      alive_q        <= '1;
    end else if (step_i) begin
      line_count_q   <= line_count_d;
      digit_count_q  <= digit_count_d;
      id_accum_q     <= id_accum_d;
      length_digit_q <= length_digit_d;
      byte_store_q   <= byte_store_d;
      bad_char_q     <= bad_char_d;
      alive_q        <= alive_d;
    end
  end

endmodule
